/* sv/ddo_pkg.sv */
// Shared constants, types and the arctangent table for the odometry block.
// No dependencies.
package ddo_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 64;
  localparam int NUM_W        = 64;
  localparam int DEN_W        = 48;
  localparam int CS_W         = 34;

  localparam logic [15:0] PERIOD_RST    = 16'd50;
  localparam logic [11:0] TRACK_RST     = 12'd142;
  localparam logic [11:0] THRESH_RST    = 12'd5;
  localparam logic [29:0] TURN_SCALE    = 30'd683565276;
  localparam logic [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);
  localparam logic [DEN_W-1:0] STR_DEN  = DEN_W'(64'd32768000000);
  localparam logic [9:0] MS_PER_S       = 10'd1000;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_TRACK  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* sv/differential_drive_odometry_top.sv */
// Differential-drive odometry: sequencer, pose registers and stream ports.
// Depends on ddo_pkg, ddo_div and ddo_cordic.

// One input word is taken at a time; in_tready is high only while the block
// is idle. A clear, or a word with no update due, goes straight to the output
// step. An update runs a 64-step serial divider for the heading step and a
// 30-step CORDIC for the current heading, then two more divider runs for x
// and y (straight), nothing more (point turn), or a second CORDIC and two
// divider runs (arc). A result still waiting at the output holds the next word
// in its last step, and the input stays closed until that result is taken.
module differential_drive_odometry_top
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // now_ms, speed_left, speed_right, target_left, target_right
  input  logic [95:0] in_tdata,
  // kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // x_pos, y_pos, heading
  output logic [95:0] out_tdata,
  // did_update
  output logic        out_tuser
);

  localparam logic [3:0] S_IDLE = 4'd0,  S_M0 = 4'd1,  S_M1 = 4'd2,   S_M2 = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4,  S_M4 = 4'd5,  S_M5 = 4'd6,   S_DIVA = 4'd7;
  localparam logic [3:0] S_COR0 = 4'd8,  S_COR1 = 4'd9, S_MD = 4'd10, S_MDW = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]  state_r;
  logic [15:0] period_r;
  logic [11:0] track_r, thresh_r;
  logic [31:0] pos_x_r, pos_y_r, ang_r, last_r, da_r;
  logic        did_r, out_valid_r;
  logic [95:0] out_data_r;
  logic        out_user_r;

  logic signed [15:0] sl_r, sr_r, tl_r, tr_r;
  logic signed [16:0] d, s;
  logic [16:0]        ad, as;
  logic [11:0]        w;
  logic               str_r, pt_r, sneg_r, dneg_r;
  logic [21:0]        wk_r;
  logic [32:0]        p1_r, st_r;
  logic [28:0]        ws_r;
  logic [DEN_W-1:0]   dena_r;
  logic signed [CS_W-1:0] c0_r, s0_r, c1_r;
  logic [32:0]        ma_r, mb_r;
  logic [DEN_W-1:0]   mden_r;
  logic               mneg_r, phy_r;

  unit_stat_t         div_st, cor_st;
  logic [31:0]        div_q;
  logic               div_go, cor_go;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_neg;
  logic [31:0]        cor_ang;
  logic signed [CS_W-1:0] cor_c, cor_s;
  logic signed [CS_W:0]   dsin, dcos;
  logic [65:0]        md_prod;

  function automatic logic [32:0] mag35(input logic signed [CS_W:0] v);
    logic signed [CS_W:0] a;
    a = (v < 0) ? -v : v;
    return a[32:0];
  endfunction

  assign d  = 17'(sr_r) - 17'(sl_r);
  assign s  = 17'(sr_r) + 17'(sl_r);
  assign ad = (d < 0) ? 17'(-d) : 17'(d);
  assign as = (s < 0) ? 17'(-s) : 17'(s);
  assign w  = (track_r == 12'd0) ? 12'd1 : track_r;

  assign dsin    = (CS_W + 1)'(cor_s) - (CS_W + 1)'(s0_r);
  assign dcos    = (CS_W + 1)'(c0_r) - (CS_W + 1)'(c1_r);
  assign md_prod = ma_r * mb_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = DEN_W'(wk_r);
    div_neg = dneg_r;
    if (state_r == S_M2) begin
      div_go  = 1'b1;
      div_num = p1_r * TURN_SCALE;
    end else if (state_r == S_MD) begin
      div_go  = 1'b1;
      div_num = md_prod[NUM_W-1:0];
      div_den = mden_r;
      div_neg = mneg_r;
    end
    cor_go  = 1'b0;
    cor_ang = ang_r;
    if (state_r == S_DIVA && div_st.done) begin
      cor_go = 1'b1;
    end else if (state_r == S_COR0 && cor_st.done && !str_r && !pt_r) begin
      cor_go  = 1'b1;
      cor_ang = ang_r + da_r;
    end
  end

  ddo_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num_mag(div_num), .den(div_den),
    .neg(div_neg), .stat(div_st), .quot(div_q)
  );

  ddo_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_go), .ang(cor_ang), .stat(cor_st),
    .cos_o(cor_c), .sin_o(cor_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RST;
      track_r     <= TRACK_RST;
      thresh_r    <= THRESH_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      ang_r       <= '0;
      last_r      <= '0;
      did_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PERIOD: period_r <= cfg_wdata;
          REG_TRACK:  track_r  <= cfg_wdata[11:0];
          REG_THRESH: thresh_r <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sl_r <= in_tdata[47:32];
            sr_r <= in_tdata[63:48];
            tl_r <= in_tdata[79:64];
            tr_r <= in_tdata[95:80];
            if (in_tuser) begin
              pos_x_r <= '0;
              pos_y_r <= '0;
              ang_r   <= '0;
              last_r  <= in_tdata[31:0];
              did_r   <= 1'b0;
              state_r <= S_OUT;
            end else if ((in_tdata[31:0] - last_r) >= 32'(period_r)) begin
              last_r  <= in_tdata[31:0];
              did_r   <= 1'b1;
              state_r <= S_M0;
            end else begin
              did_r   <= 1'b0;
              state_r <= S_OUT;
            end
          end
        end
        S_M0: begin
          wk_r    <= w * MS_PER_S;
          str_r   <= (tl_r == tr_r) || (ad <= 17'(thresh_r));
          pt_r    <= ((17'(tl_r) == -17'(tr_r))) || (as <= 17'(thresh_r));
          sneg_r  <= s < 0;
          dneg_r  <= d < 0;
          state_r <= S_M1;
        end
        S_M1: begin
          p1_r    <= ad * period_r;
          state_r <= S_M2;
        end
        S_M2: state_r <= S_M3;
        S_M3: begin
          st_r    <= as * period_r;
          state_r <= S_M4;
        end
        S_M4: begin
          ws_r    <= w * as;
          state_r <= S_M5;
        end
        S_M5: begin
          dena_r  <= DEN_W'(ad * MS_PER_S) << 15;
          state_r <= S_DIVA;
        end
        S_DIVA: begin
          if (div_st.done) begin
            da_r    <= div_q;
            state_r <= S_COR0;
          end
        end
        S_COR0: begin
          if (cor_st.done) begin
            c0_r <= cor_c;
            s0_r <= cor_s;
            if (str_r) begin
              ma_r    <= st_r;
              mb_r    <= mag35((CS_W + 1)'(cor_c));
              mneg_r  <= sneg_r ^ (cor_c < 0);
              mden_r  <= STR_DEN;
              phy_r   <= 1'b0;
              state_r <= S_MD;
            end else if (pt_r) begin
              ang_r   <= ang_r + da_r;
              state_r <= S_OUT;
            end else begin
              state_r <= S_COR1;
            end
          end
        end
        S_COR1: begin
          if (cor_st.done) begin
            c1_r    <= cor_c;
            ma_r    <= 33'(ws_r);
            mb_r    <= mag35(dsin);
            mneg_r  <= sneg_r ^ dneg_r ^ (dsin < 0);
            mden_r  <= dena_r;
            phy_r   <= 1'b0;
            state_r <= S_MD;
          end
        end
        S_MD: state_r <= S_MDW;
        S_MDW: begin
          if (div_st.done) begin
            if (!phy_r) begin
              pos_x_r <= pos_x_r + div_q;
              phy_r   <= 1'b1;
              if (str_r) begin
                mb_r   <= mag35((CS_W + 1)'(s0_r));
                mneg_r <= sneg_r ^ (s0_r < 0);
              end else begin
                mb_r   <= mag35(dcos);
                mneg_r <= sneg_r ^ dneg_r ^ (dcos < 0);
              end
              state_r <= S_MD;
            end else begin
              pos_y_r <= pos_y_r + div_q;
              if (!str_r) ang_r <= ang_r + da_r;
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {ang_r, pos_y_r, pos_x_r};
            out_user_r  <= did_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_busy_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!div_st.busy && !cor_st.busy))
    else $error("arithmetic unit busy while idle");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_go && div_st.busy))
    else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("pending result changed");
`endif

endmodule

/* sv/ddo_div.sv */
// Bit-serial restoring divider, rounding half away from zero, signed result.
// Depends on ddo_pkg.
module ddo_div
  import ddo_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num_mag,
  input  logic [DEN_W-1:0] den,
  input  logic             neg,
  output unit_stat_t       stat,
  output logic [31:0]      quot
);

  logic [NUM_W-1:0] n_r, n_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [5:0]       it_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    rem_sh  = {rem_r[DEN_W-1:0], n_r[NUM_W-1]};
    rem_nxt = rem_sh;
    n_nxt   = {n_r[NUM_W-2:0], 1'b0};
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt  = rem_sh - {1'b0, den_r};
      n_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
        n_r    <= num_mag + NUM_W'(den >> 1);
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= neg;
      end else if (busy_r) begin
        n_r   <= n_nxt;
        rem_r <= rem_nxt;
        it_r  <= it_r + 6'd1;
        if (it_r == 6'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = neg_r ? (32'd0 - n_r[31:0]) : n_r[31:0];

endmodule

/* sv/ddo_cordic.sv */
// Iterative rotation CORDIC giving Q30 cosine and sine of a binary angle.
// Depends on ddo_pkg.
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [31:0]            ang,
  output unit_stat_t             stat,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  logic signed [CS_W-1:0] x_r, y_r;
  logic signed [33:0]     z_r, z0;
  logic                   flip_r, flip0;
  logic [4:0]             it_r;
  logic                   busy_r, done_r;
  logic signed [CS_W-1:0] xs, ys;
  logic signed [33:0]     at;

  always_comb begin
    z0    = 34'(signed'(ang));
    flip0 = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0    = z0 - 34'sd2147483648;
      flip0 = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0    = z0 + 34'sd2147483648;
      flip0 = 1'b1;
    end
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    at = signed'({2'b00, atan_bam(it_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
        x_r    <= signed'(CORDIC_GAIN);
        y_r    <= '0;
        z_r    <= z0;
        flip_r <= flip0;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        it_r <= it_r + 5'd1;
        if (it_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign cos_o     = flip_r ? -x_r : x_r;
  assign sin_o     = flip_r ? -y_r : y_r;

endmodule
